// File: rtl/bta_pkg.sv
// ---------------------------------------------------------------------------
// Buddy tree allocator package
// Shared sizes, node marks, status codes, request type and FSM states.
// ---------------------------------------------------------------------------
package bta_pkg;

  // Pool geometry
  localparam int POOL_LOG2      = 12;
  localparam int MIN_BLOCK_LOG2 = 4;
  localparam int EFF_MIN_LOG2   = (MIN_BLOCK_LOG2 > POOL_LOG2) ? POOL_LOG2 : MIN_BLOCK_LOG2;
  localparam int DEEPEST        = POOL_LOG2 - EFF_MIN_LOG2;
  localparam int NODE_W         = DEEPEST + 1;
  localparam int NODE_COUNT     = 2 ** NODE_W;
  localparam int LVL_W          = $clog2(DEEPEST + 2);

  // Field widths
  localparam int OFF_W    = 12;
  localparam int REQ_W    = 13;
  localparam int K_W      = $clog2(REQ_W + 1);
  localparam int STATUS_W = 2;

  // Request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Node marks
  localparam logic [1:0] MARK_EMPTY  = 2'd0;
  localparam logic [1:0] MARK_SPLIT  = 2'd1;
  localparam logic [1:0] MARK_FILLED = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_e;

  // Classified request passed from front to back
  typedef struct packed {
    op_e              op;
    logic [LVL_W-1:0] lvl;
    logic [OFF_W-1:0] target;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_NODE,
    ST_A_NODE_D,
    ST_A_ANC,
    ST_A_ANC_D,
    ST_A_EVAL,
    ST_A_MARK,
    ST_A_UP,
    ST_F_WALK,
    ST_F_RD,
    ST_F_RD_D,
    ST_M_RD,
    ST_M_RD_D,
    ST_M_LEFT_D,
    ST_M_RIGHT_D
  } eng_state_e;

  // Byte offset of a heap-ordered node
  function automatic logic [OFF_W-1:0] offset_of(input logic [NODE_W-1:0] v);
    logic [LVL_W-1:0]  lvl;
    logic [NODE_W-1:0] rel;
    logic [31:0]       wide;
    lvl = '0;
    for (int b = 0; b < NODE_W; b++) begin
      if (v[b]) lvl = LVL_W'(b);
    end
    rel  = v & ~(NODE_W'(1) << lvl);
    wide = 32'(rel) << (POOL_LOG2 - int'(lvl));
    return wide[OFF_W-1:0];
  endfunction

endpackage

// File: rtl/buddy_tree_allocator_top.sv
// Allocation scans every node of the target tree level and walks the ancestors
// of each empty node; a free descends to the target and merges upwards; both
// go through the single read port of the node mark memory. One request is
// worked on at a time, two more can queue.
// Reset: a pass over all 512 nodes empties the mark memory; no request is taken meanwhile.
// ---------------------------------------------------------------------------
// Buddy tree allocator top level
// Front end, request queue and tree engine with its result register.
// ---------------------------------------------------------------------------
module buddy_tree_allocator_top import bta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [OFF_W-1:0]    free_offset_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OFF_W-1:0]    block_offset_o,
  output logic [STATUS_W-1:0] status_o
);

  logic push, full, q_valid, pop, clear_done;
  cmd_t push_cmd, q_cmd;

  bta_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .free_offset_i   (free_offset_i),
    .q_full_i        (full),
    .clear_done_i    (clear_done),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  bta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_cmd),
    .pop_i   (pop)
  );

  bta_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (pop),
    .clear_done_o   (clear_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_offset_o (block_offset_o),
    .status_o       (status_o)
  );

endmodule

// File: rtl/bta_front.sv
// ---------------------------------------------------------------------------
// Buddy tree allocator front end
// Accepts requests, sizes allocations to a tree level and queues them.
// ---------------------------------------------------------------------------
module bta_front import bta_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [REQ_W-1:0] request_bytes_i,
  input  logic [OFF_W-1:0] free_offset_i,
  input  logic             q_full_i,
  input  logic             clear_done_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [REQ_W-1:0] nm1;
  logic [K_W-1:0]   k;
  logic             too_big;
  logic [K_W:0]     room;

  assign in_ready_o = clear_done_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Round size up to a power of two (zero counts as one byte)
  always_comb begin
    nm1 = (request_bytes_i == '0) ? '0 : request_bytes_i - REQ_W'(1);
    k   = '0;
    for (int b = 0; b < REQ_W; b++) begin
      if (nm1[b]) k = K_W'(b + 1);
    end
    too_big = (int'(k) > POOL_LOG2);
    room    = (K_W + 1)'(POOL_LOG2) - (K_W + 1)'(k);
  end

  // Classify
  always_comb begin
    cmd_o.target = free_offset_i;
    cmd_o.lvl    = '0;
    if (cmd_i) begin
      cmd_o.op = OP_FREE;
    end else if (too_big) begin
      cmd_o.op = OP_REJECT;
    end else begin
      cmd_o.op  = OP_ALLOC;
      cmd_o.lvl = (int'(room) > DEEPEST) ? LVL_W'(DEEPEST) : LVL_W'(room);
    end
  end

endmodule

// File: rtl/bta_queue.sv
// ---------------------------------------------------------------------------
// Buddy tree allocator request queue
// Short FIFO that decouples request intake from tree updates.
// ---------------------------------------------------------------------------
module bta_queue import bta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  cmd_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_CW-1:0] cnt_q;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QUEUE_CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/bta_engine.sv
// ---------------------------------------------------------------------------
// Buddy tree allocator engine
// Owns the node mark memory; runs allocation scans, frees and merges.
// ---------------------------------------------------------------------------
module bta_engine import bta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  output logic                clear_done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OFF_W-1:0]    block_offset_o,
  output logic [STATUS_W-1:0] status_o
);

  eng_state_e        state_q, state_d;
  logic [NODE_W:0]   i_q, i_d, last_q, last_d, v_q, v_d;
  logic [NODE_W-1:0] p_q, p_d, near_q, near_d, best_q, best_d, best_near_q, best_near_d;
  logic [NODE_W-1:0] pos_q, pos_d, clr_q, clr_d;
  logic              found_q, found_d;
  logic [1:0]        mleft_q, mleft_d;
  logic [OFF_W-1:0]  target_q, target_d;

  logic              res_valid_q;
  logic [OFF_W-1:0]  res_off_q;
  logic [STATUS_W-1:0] res_status_q;
  logic              res_set;
  logic [OFF_W-1:0]  res_off;
  logic [STATUS_W-1:0] res_status;

  // Mark memory, one write and one registered read port
  logic [1:0]        mem [NODE_COUNT];
  logic              we;
  logic [NODE_W-1:0] wa, ra;
  logic [1:0]        wd, rd_q;

  logic [NODE_W:0]   i_inc, v2;
  logic              i_end;
  logic [NODE_W-1:0] p_up, pos_up, best_up;
  logic [OFF_W-1:0]  off_v, off_right;

  assign clear_done_o   = (state_q != ST_CLEAR);
  assign out_valid_o    = res_valid_q;
  assign block_offset_o = res_off_q;
  assign status_o       = res_status_q;

  assign i_inc     = i_q + (NODE_W + 1)'(1);
  assign i_end     = (i_inc == last_q);
  assign v2        = v_q << 1;
  assign p_up      = p_q >> 1;
  assign pos_up    = pos_q >> 1;
  assign best_up   = best_q >> 1;
  assign off_v     = offset_of(v_q[NODE_W-1:0]);
  assign off_right = offset_of(v2[NODE_W-1:0] | NODE_W'(1));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // Next state and memory control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    last_d      = last_q;
    v_d         = v_q;
    p_d         = p_q;
    near_d      = near_q;
    best_d      = best_q;
    best_near_d = best_near_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    found_d     = found_q;
    mleft_d     = mleft_q;
    target_d    = target_q;
    we          = 1'b0;
    wa          = '0;
    wd          = MARK_EMPTY;
    ra          = '0;
    q_pop_o     = 1'b0;
    res_set     = 1'b0;
    res_off     = '0;
    res_status  = STATUS_OK;

    case (state_q)
      // Sweep the memory to empty after reset
      ST_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == '1) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (q_valid_i && !res_valid_q) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_ALLOC: begin
              i_d         = (NODE_W + 1)'(1) << q_cmd_i.lvl;
              last_d      = (NODE_W + 1)'(2) << q_cmd_i.lvl;
              found_d     = 1'b0;
              best_d      = '0;
              best_near_d = '0;
              state_d     = ST_A_NODE;
            end
            OP_FREE: begin
              v_d      = (NODE_W + 1)'(1);
              target_d = q_cmd_i.target;
              state_d  = ST_F_WALK;
            end
            default: begin
              res_set    = 1'b1;
              res_status = STATUS_NO_SPACE;
            end
          endcase
        end
      end

      // Allocation: scan every node of the level
      ST_A_NODE: begin
        ra      = i_q[NODE_W-1:0];
        state_d = ST_A_NODE_D;
      end

      ST_A_NODE_D: begin
        if (rd_q != MARK_EMPTY) begin
          i_d     = i_inc;
          state_d = i_end ? ST_A_MARK : ST_A_NODE;
        end else begin
          p_d     = i_q[NODE_W-1:0] >> 1;
          near_d  = '0;
          state_d = ((i_q[NODE_W-1:0] >> 1) == '0) ? ST_A_EVAL : ST_A_ANC;
        end
      end

      // Walk ancestors: blocked by a filled one, note nearest split one
      ST_A_ANC: begin
        ra      = p_q;
        state_d = ST_A_ANC_D;
      end

      ST_A_ANC_D: begin
        if (rd_q == MARK_FILLED) begin
          i_d     = i_inc;
          state_d = i_end ? ST_A_MARK : ST_A_NODE;
        end else begin
          if (rd_q == MARK_SPLIT && near_q == '0) near_d = p_q;
          p_d     = p_up;
          state_d = (p_up == '0) ? ST_A_EVAL : ST_A_ANC;
        end
      end

      ST_A_EVAL: begin
        if (!found_q || near_q > best_near_q) begin
          found_d     = 1'b1;
          best_near_d = near_q;
          best_d      = i_q[NODE_W-1:0];
        end
        i_d     = i_inc;
        state_d = i_end ? ST_A_MARK : ST_A_NODE;
      end

      // Mark the winner filled, then its ancestors split
      ST_A_MARK: begin
        if (!found_q) begin
          res_set    = 1'b1;
          res_status = STATUS_NO_SPACE;
          state_d    = ST_IDLE;
        end else begin
          we  = 1'b1;
          wa  = best_q;
          wd  = MARK_FILLED;
          p_d = best_up;
          if (best_up == '0) begin
            res_set = 1'b1;
            res_off = offset_of(best_q);
            state_d = ST_IDLE;
          end else begin
            state_d = ST_A_UP;
          end
        end
      end

      ST_A_UP: begin
        we  = 1'b1;
        wa  = p_q;
        wd  = MARK_SPLIT;
        p_d = p_up;
        if (p_up == '0) begin
          res_set = 1'b1;
          res_off = offset_of(best_q);
          state_d = ST_IDLE;
        end
      end

      // Free: descend towards the target offset
      ST_F_WALK: begin
        if (v_q >= (NODE_W + 1)'(NODE_COUNT)) begin
          res_set    = 1'b1;
          res_status = STATUS_NOT_FOUND;
          state_d    = ST_IDLE;
        end else if (off_v == target_q) begin
          state_d = ST_F_RD;
        end else if (v2 >= (NODE_W + 1)'(NODE_COUNT)) begin
          res_set    = 1'b1;
          res_status = STATUS_NOT_FOUND;
          state_d    = ST_IDLE;
        end else begin
          v_d = (off_right <= target_q) ? (v2 | (NODE_W + 1)'(1)) : v2;
        end
      end

      ST_F_RD: begin
        ra      = v_q[NODE_W-1:0];
        state_d = ST_F_RD_D;
      end

      ST_F_RD_D: begin
        if (rd_q == MARK_FILLED) begin
          pos_d   = v_q[NODE_W-1:0];
          state_d = ST_M_RD;
        end else if (rd_q == MARK_SPLIT) begin
          v_d     = v2;
          state_d = ST_F_WALK;
        end else begin
          res_set    = 1'b1;
          res_status = STATUS_NOT_FOUND;
          state_d    = ST_IDLE;
        end
      end

      // Merge upwards: clear the block, empty parents of two empty children
      ST_M_RD: begin
        ra      = pos_q;
        state_d = ST_M_RD_D;
      end

      ST_M_RD_D: begin
        if (rd_q == MARK_SPLIT && !pos_q[NODE_W-1]) begin
          ra      = NODE_W'(pos_q << 1);
          state_d = ST_M_LEFT_D;
        end else begin
          if (rd_q == MARK_FILLED) begin
            we = 1'b1;
            wa = pos_q;
          end
          pos_d = pos_up;
          if (pos_up == '0) begin
            res_set = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_M_RD;
          end
        end
      end

      ST_M_LEFT_D: begin
        mleft_d = rd_q;
        ra      = NODE_W'(pos_q << 1) | NODE_W'(1);
        state_d = ST_M_RIGHT_D;
      end

      ST_M_RIGHT_D: begin
        if (mleft_q == MARK_EMPTY && rd_q == MARK_EMPTY) begin
          we = 1'b1;
          wa = pos_q;
        end
        pos_d = pos_up;
        if (pos_up == '0) begin
          res_set = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_M_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    last_q      <= last_d;
    v_q         <= v_d;
    p_q         <= p_d;
    near_q      <= near_d;
    best_q      <= best_d;
    best_near_q <= best_near_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    mleft_q     <= mleft_d;
    target_q    <= target_d;
    if (res_set) begin
      res_off_q    <= res_off;
      res_status_q <= res_status;
    end
  end

endmodule
